// ----- rtl/swhsr_pkg.sv -----
`default_nettype none
package swhsr_pkg;

  // func codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // line_mode codes
  localparam logic [1:0] MODE_RELEASE = 2'd0;
  localparam logic [1:0] MODE_LOW     = 2'd1;
  localparam logic [1:0] MODE_HIGH    = 2'd2;

  // sequencer phases
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_START_LOW  = 4'd1;
  localparam logic [3:0] PH_START_HIGH = 4'd2;
  localparam logic [3:0] PH_RESP_WAIT  = 4'd3;
  localparam logic [3:0] PH_RESP_CHECK = 4'd4;
  localparam logic [3:0] PH_RESP_END   = 4'd5;
  localparam logic [3:0] PH_BIT_LOW    = 4'd6;
  localparam logic [3:0] PH_BIT_DELAY  = 4'd7;
  localparam logic [3:0] PH_BIT_HIGH   = 4'd8;

  // config register indexes
  localparam logic [2:0] REG_START_LOW    = 3'd0;
  localparam logic [2:0] REG_START_HIGH   = 3'd1;
  localparam logic [2:0] REG_RESP_WAIT    = 3'd2;
  localparam logic [2:0] REG_RESP_CHECK   = 3'd3;
  localparam logic [2:0] REG_SAMPLE_DELAY = 3'd4;
  localparam logic [2:0] REG_TIMEOUT      = 3'd5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef struct packed {
    logic [1:0] line_mode;
    logic       busy_res;
    logic       op_done;
    logic       response_ok;
    logic [7:0] data_byte;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/single_wire_humidity_sensor_reader.sv -----
// Result timing: a result is valid the cycle after its input transfer unless an earlier result is stalled.
// Throughput: one input transfer per cycle, sustained while results drain;
//   a two-entry output buffer lets one more item in while a result is stalled.
// Reset (rst_ni, async, active low): sequencer idle, counters and data cleared,
//   config registers back to 18000/10/40/80/40/2000, output buffer empty.
`default_nettype none
module single_wire_humidity_sensor_reader #(
  parameter int unsigned BITS_PER_READ = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config write port
  input  wire logic                              cfg_we_i,
  input  wire logic [swhsr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [swhsr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        func_i,
  input  wire logic                              line_level_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [1:0]                             line_mode_o,
  output logic                                   busy_res_o,
  output logic                                   op_done_o,
  output logic                                   response_ok_o,
  output logic [7:0]                             data_byte_o
);
  import swhsr_pkg::*;

  logic accept;
  logic full;
  res_t res_next, res_out;

  // A transfer is taken whenever the skid entry is free; the sequencer state
  // advances in the same edge, so ticks may arrive every cycle.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Phase sequencer: one tick per transfer, result computed from next state.
  swhsr_core #(
    .BITS_PER_READ(BITS_PER_READ)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .func_i       (func_i),
    .line_level_i (line_level_i),
    .res_o        (res_next)
  );

  // Result register plus skid entry.
  swhsr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res_next),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign line_mode_o   = res_out.line_mode;
  assign busy_res_o    = res_out.busy_res;
  assign op_done_o     = res_out.op_done;
  assign response_ok_o = res_out.response_ok;
  assign data_byte_o   = res_out.data_byte;

endmodule
`default_nettype wire

// ----- rtl/swhsr_core.sv -----
`default_nettype none
module swhsr_core #(
  parameter int unsigned BITS_PER_READ = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [swhsr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [swhsr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                                accept_i,
  input  wire logic [1:0]                          func_i,
  input  wire logic                                line_level_i,
  output swhsr_pkg::res_t                          res_o
);
  import swhsr_pkg::*;

  localparam int unsigned BIT_W = $clog2(BITS_PER_READ + 1);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_READ - 1);

  // config registers
  logic [15:0] start_low_q, timeout_q;
  logic [7:0]  start_high_q, resp_wait_q, resp_check_q, sample_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q    <= 16'd18000;
      start_high_q   <= 8'd10;
      resp_wait_q    <= 8'd40;
      resp_check_q   <= 8'd80;
      sample_delay_q <= 8'd40;
      timeout_q      <= 16'd2000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_LOW:    start_low_q    <= cfg_wdata_i;
        REG_START_HIGH:   start_high_q   <= cfg_wdata_i[7:0];
        REG_RESP_WAIT:    resp_wait_q    <= cfg_wdata_i[7:0];
        REG_RESP_CHECK:   resp_check_q   <= cfg_wdata_i[7:0];
        REG_SAMPLE_DELAY: sample_delay_q <= cfg_wdata_i[7:0];
        REG_TIMEOUT:      timeout_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [3:0]       phase_q, phase_d;
  logic [15:0]      cnt_q, cnt_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  logic [7:0]       shift_q, shift_d;
  logic             resp_q, resp_d;
  logic             done;

  logic [15:0] limit;
  logic [16:0] cnt_inc;
  logic        hit;

  always_comb begin
    case (phase_q)
      PH_START_LOW:  limit = start_low_q;
      PH_START_HIGH: limit = {8'd0, start_high_q};
      PH_RESP_WAIT:  limit = {8'd0, resp_wait_q};
      PH_RESP_CHECK: limit = {8'd0, resp_check_q};
      PH_BIT_DELAY:  limit = {8'd0, sample_delay_q};
      default:       limit = timeout_q;
    endcase
  end

  assign cnt_inc = {1'b0, cnt_q} + 17'd1;
  // limit of zero acts as one
  assign hit     = cnt_inc >= {1'b0, limit};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    resp_d  = resp_q;
    done    = 1'b0;
    if (accept_i) begin
      case (func_i)
        FUNC_TICK: begin
          if (phase_q != PH_IDLE) begin
            cnt_d = hit ? 16'd0 : cnt_inc[15:0];
            case (phase_q)
              PH_START_LOW:  if (hit) phase_d = PH_START_HIGH;
              PH_START_HIGH: if (hit) phase_d = PH_RESP_WAIT;
              PH_RESP_WAIT: begin
                if (hit) phase_d = line_level_i ? PH_RESP_END : PH_RESP_CHECK;
              end
              PH_RESP_CHECK: begin
                if (hit) begin
                  if (line_level_i) resp_d = 1'b1;
                  phase_d = PH_RESP_END;
                end
              end
              PH_RESP_END: begin
                if (!line_level_i || hit) begin
                  phase_d = PH_IDLE;
                  cnt_d   = 16'd0;
                  done    = 1'b1;
                end
              end
              PH_BIT_LOW: begin
                if (line_level_i || hit) begin
                  phase_d = PH_BIT_DELAY;
                  cnt_d   = 16'd0;
                end
              end
              PH_BIT_DELAY: begin
                if (hit) begin
                  shift_d = {shift_q[6:0], line_level_i};
                  phase_d = PH_BIT_HIGH;
                end
              end
              PH_BIT_HIGH: begin
                if (!line_level_i || hit) begin
                  bit_d = bit_q + BIT_W'(1);
                  cnt_d = 16'd0;
                  if (bit_q == LAST_BIT) begin
                    phase_d = PH_IDLE;
                    done    = 1'b1;
                  end else begin
                    phase_d = PH_BIT_LOW;
                  end
                end
              end
              default: begin
                phase_d = PH_IDLE;
                cnt_d   = 16'd0;
              end
            endcase
          end
        end
        FUNC_START: begin
          if (phase_q == PH_IDLE) begin
            resp_d  = 1'b0;
            phase_d = PH_START_LOW;
            cnt_d   = 16'd0;
          end
        end
        FUNC_READ: begin
          if (phase_q == PH_IDLE) begin
            shift_d = 8'd0;
            bit_d   = '0;
            phase_d = PH_BIT_LOW;
            cnt_d   = 16'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= 16'd0;
      bit_q   <= '0;
      shift_q <= 8'd0;
      resp_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      resp_q  <= resp_d;
    end
  end

  always_comb begin
    case (phase_d)
      PH_START_LOW:  res_o.line_mode = MODE_LOW;
      PH_START_HIGH: res_o.line_mode = MODE_HIGH;
      default:       res_o.line_mode = MODE_RELEASE;
    endcase
    res_o.busy_res    = phase_d != PH_IDLE;
    res_o.op_done     = done;
    res_o.response_ok = resp_d;
    res_o.data_byte   = shift_d;
  end

endmodule
`default_nettype wire

// ----- rtl/swhsr_out_buf.sv -----
`default_nettype none
module swhsr_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire swhsr_pkg::res_t  res_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output swhsr_pkg::res_t       res_o
);
  import swhsr_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic pop;

  assign pop = out_valid_q && !out_stall_i;

  // push only happens when skid is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q) begin
      skid_valid_q <= skid_valid_q || push_i;
    end else begin
      out_valid_q  <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (!out_valid_q) begin
      out_q <= res_i;
    end
    if (!pop && out_valid_q && push_i) skid_q <= res_i;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
`default_nettype wire
